[src/registration_cache_slot_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Registration cache slot allocator: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef REGISTRATION_CACHE_SLOT_ALLOCATOR_MACROS_SVH
`define REGISTRATION_CACHE_SLOT_ALLOCATOR_MACROS_SVH

// Check a property at every clock edge outside reset.
`define RCSA_ASSERT_NOW(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define RCSA_ASSERT_NEXT(lbl, ck, rs, trig, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (trig) |=> (cond)) else $error(msg);

`endif

[src/rcsa_pkg.sv]
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared constants, record layout and command types of the slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int USE_BITS_DEF = 16;
  localparam int ID_MAX_W     = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_CACHE_EN = 2'd0;
  localparam logic [1:0] CFG_SHARED   = 2'd1;

  // Input kind carried on tuser
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // Slot flag bit positions (liveness is the memory valid bit)
  localparam int FLAG_VECT = 0;
  localparam int FLAG_RES  = 1;
  localparam int FLAG_IDLE = 2;
  localparam int FLAG_W    = 3;

  // Record layout in the slot memory
  localparam int STAMP_W   = 32;
  localparam int REC_VADDR = 0;
  localparam int REC_LEN   = 64;
  localparam int REC_LST   = 96;
  localparam int REC_IST   = REC_LST + STAMP_W;
  localparam int REC_FLAGS = REC_IST + STAMP_W;
  localparam int REC_USERS = REC_FLAGS + FLAG_W;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic                pop;
    logic                push;
    logic [ID_MAX_W-1:0] id;
  } fl_cmd_t;

endpackage

[src/rcsa_slot_mem.sv]
// ----------------------------------------------------------------------------
// rcsa_slot_mem
// Slot record memory, one read and one write port, registered read data,
// with a live bit per slot that reset clears.
// ----------------------------------------------------------------------------
module rcsa_slot_mem #(
  parameter int SLOTS = rcsa_pkg::SLOTS_DEF,
  parameter int REC_W = 200
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [REC_W-1:0]         rd_data,
  output logic                     rd_live,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [REC_W-1:0]         wr_data,
  input  logic                     wr_live
);

  logic [REC_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] live;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr_en) begin
        live[wr_addr] <= wr_live;
      end
      if (rd_en) begin
        rd_live <= live[rd_addr];
      end
    end
  end

endmodule

[src/rcsa_free_list.sv]
// ----------------------------------------------------------------------------
// rcsa_free_list
// LIFO free list of slots: link memory, head and count. A link never
// written reads as the next slot index.
// ----------------------------------------------------------------------------
module rcsa_free_list #(
  parameter int SLOTS = rcsa_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rcsa_pkg::fl_cmd_t          cmd,
  output logic [$clog2(SLOTS)-1:0]   head_id,
  output logic [$clog2(SLOTS+1)-1:0] count
);

  localparam int IDW = $clog2(SLOTS);
  localparam int LW  = $clog2(SLOTS + 1);

  logic [LW-1:0]    link_mem [SLOTS];
  logic [SLOTS-1:0] link_ok;
  logic [LW-1:0]    head;
  logic [LW-1:0]    link_q;
  logic             link_ok_q;
  logic [LW-1:0]    link_dflt;
  logic             pend;
  logic [IDW-1:0]   cmd_idx;

  assign head_id = head[IDW-1:0];
  assign cmd_idx = IDW'(cmd.id);

  // Read the successor of the head on a pop; write the link on a push.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      link_mem[cmd_idx] <= head;
    end
    if (cmd.pop) begin
      link_q    <= link_mem[head[IDW-1:0]];
      link_dflt <= head + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_ok   <= '0;
      link_ok_q <= 1'b0;
      head      <= '0;
      count     <= LW'(SLOTS);
      pend      <= 1'b0;
    end else begin
      pend <= cmd.pop;
      if (cmd.pop) begin
        link_ok_q <= link_ok[head[IDW-1:0]];
        count     <= count - 1'b1;
      end
      if (pend) begin
        head <= link_ok_q ? link_q : link_dflt;
      end
      if (cmd.push) begin
        link_ok[cmd_idx] <= 1'b1;
        head             <= LW'(cmd_idx);
        count            <= count + 1'b1;
      end
    end
  end

endmodule

[src/registration_cache_slot_allocator.sv]
// Timing: a put, or a get with caching off, has its result registered from one finishing
//   state, S_PMOD or S_ALLOC; with caching on a get scans one slot record per cycle in
//   S_SCAN, then S_DECIDE, then S_ALLOC when it allocates; output stalls hold the finishing state.
// Flow: one transaction at a time; the next is taken the cycle after the result is registered.
// Reset: synchronous; all slots free, caching on, shared reuse off.
// ----------------------------------------------------------------------------
// registration_cache_slot_allocator
// Slot allocator for a registration cache: free list plus scanned records.
// ----------------------------------------------------------------------------
`include "registration_cache_slot_allocator_macros.svh"

module registration_cache_slot_allocator #(
  parameter int SLOTS    = rcsa_pkg::SLOTS_DEF,
  parameter int USE_BITS = rcsa_pkg::USE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: req_vaddr[63:0], req_length[95:64], vectorial[96], reserve[97],
  //        put_slot[103:98], reg_refused[104], zero fill above
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rcsa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode[0]
  input  logic                            s_axis_tuser,
  // tdata: status[0], got_id[6:1], hit[7], users_after[23:8], evicted[24],
  //        evicted_id[30:25], destroyed[31], free_left[38:32], zero fill
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rcsa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic                            cfg_data
);

  localparam int IDW     = $clog2(SLOTS);
  localparam int LW      = $clog2(SLOTS + 1);
  localparam int REC_W   = rcsa_pkg::REC_USERS + USE_BITS;
  localparam int STAMP_W = rcsa_pkg::STAMP_W;
  localparam int FLAG_W  = rcsa_pkg::FLAG_W;
  localparam logic [USE_BITS-1:0] USE_MAX = '1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PMOD   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_ALLOC  = 6'b010000,
    S_UNUSED = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic cache_enable;
  logic shared_reuse;

  // Held request
  logic [63:0]         req_vaddr;
  logic [31:0]         req_length;
  logic                req_vect;
  logic                req_res;
  logic [IDW-1:0]      req_idx;
  logic                req_bad;
  logic                req_refused;

  // Scan bookkeeping
  logic [LW-1:0]       scan_cnt;
  logic                eval_vld;
  logic [IDW-1:0]      eval_addr;
  logic                found;
  logic [IDW-1:0]      best_addr;
  logic [STAMP_W-1:0]  best_stamp;
  logic [REC_W-1:0]    best_rec;
  logic                old_found;
  logic [IDW-1:0]      old_addr;
  logic [STAMP_W-1:0]  old_stamp;
  logic [STAMP_W-1:0]  lcount;
  logic [STAMP_W-1:0]  icount;

  // Memory ports
  logic                mem_rd_en;
  logic [IDW-1:0]      mem_rd_addr;
  logic [REC_W-1:0]    mem_rd_data;
  logic                mem_rd_live;
  logic                mem_wr_en;
  logic [IDW-1:0]      mem_wr_addr;
  logic [REC_W-1:0]    mem_wr_data;
  logic                mem_wr_live;

  rcsa_pkg::fl_cmd_t   fl_cmd;
  logic [IDW-1:0]      fl_head;
  logic [LW-1:0]       fl_count;

  // Result assembly
  logic                go;
  logic                res_en;
  logic                r_status;
  logic [IDW-1:0]      r_got;
  logic                r_hit;
  logic [USE_BITS-1:0] r_users;
  logic                r_ev;
  logic [IDW-1:0]      r_evid;
  logic                r_dest;
  logic [LW-1:0]       r_free;
  logic [31:0]         users_wide;

  // Record fields of the current read
  logic [63:0]         rd_vaddr;
  logic [31:0]         rd_len;
  logic [STAMP_W-1:0]  rd_lst;
  logic [STAMP_W-1:0]  rd_ist;
  logic [FLAG_W-1:0]   rd_flags;
  logic [USE_BITS-1:0] rd_users;
  logic                cand;
  logic                idle_cand;
  logic [USE_BITS-1:0] put_users;
  logic [FLAG_W-1:0]   put_flags;
  logic                put_keep;
  logic                s_accept;

  assign rd_vaddr = mem_rd_data[rcsa_pkg::REC_VADDR +: 64];
  assign rd_len   = mem_rd_data[rcsa_pkg::REC_LEN +: 32];
  assign rd_lst   = mem_rd_data[rcsa_pkg::REC_LST +: STAMP_W];
  assign rd_ist   = mem_rd_data[rcsa_pkg::REC_IST +: STAMP_W];
  assign rd_flags = mem_rd_live ? mem_rd_data[rcsa_pkg::REC_FLAGS +: FLAG_W] : '0;
  assign rd_users = mem_rd_live ? mem_rd_data[rcsa_pkg::REC_USERS +: USE_BITS] : '0;

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign go            = !m_axis_tvalid || m_axis_tready;

  // Reuse candidate: a cached contiguous region that fits the request.
  assign cand = mem_rd_live && !rd_flags[rcsa_pkg::FLAG_VECT] && !req_vect
             && !(req_res && rd_flags[rcsa_pkg::FLAG_RES])
             && (shared_reuse || rd_users == '0)
             && rd_vaddr == req_vaddr && rd_len >= req_length;
  assign idle_cand = mem_rd_live && rd_flags[rcsa_pkg::FLAG_IDLE];

  // Put: lower the count, drop the reservation, park or destroy.
  always_comb begin
    put_users = (rd_users != '0) ? rd_users - 1'b1 : '0;
    put_flags = rd_flags;
    if (req_res) begin
      put_flags[rcsa_pkg::FLAG_RES] = 1'b0;
    end
    put_keep = cache_enable && !rd_flags[rcsa_pkg::FLAG_VECT];
    if (put_keep && put_users == '0) begin
      put_flags[rcsa_pkg::FLAG_IDLE] = 1'b1;
    end
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    if (s_accept) begin
      mem_rd_en   = 1'b1;
      mem_rd_addr = IDW'(s_axis_tdata[103:98]);
    end else if (state == S_SCAN && scan_cnt < LW'(SLOTS)) begin
      mem_rd_en   = 1'b1;
      mem_rd_addr = scan_cnt[IDW-1:0];
    end
  end

  // Datapath of the finishing states: record write, free list and result.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_wr_live = 1'b0;
    fl_cmd      = '0;
    res_en      = 1'b0;
    r_status    = 1'b0;
    r_got       = '0;
    r_hit       = 1'b0;
    r_users     = '0;
    r_ev        = 1'b0;
    r_evid      = '0;
    r_dest      = 1'b0;
    r_free      = fl_count;
    unique case (state)
      S_PMOD: begin
        if (go) begin
          res_en = 1'b1;
          if (req_bad || !mem_rd_live) begin
            r_status = 1'b1;
          end else if (put_keep) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = req_idx;
            mem_wr_live = 1'b1;
            mem_wr_data = mem_rd_data;
            mem_wr_data[rcsa_pkg::REC_FLAGS +: FLAG_W]   = put_flags;
            mem_wr_data[rcsa_pkg::REC_USERS +: USE_BITS] = put_users;
            if (put_users == '0 && !rd_flags[rcsa_pkg::FLAG_IDLE]) begin
              mem_wr_data[rcsa_pkg::REC_IST +: STAMP_W] = icount;
            end
            r_users = put_users;
          end else begin
            // Destroy: clear the live bit and push the slot.
            mem_wr_en   = 1'b1;
            mem_wr_addr = req_idx;
            mem_wr_live = 1'b0;
            fl_cmd.push = 1'b1;
            fl_cmd.id   = rcsa_pkg::ID_MAX_W'(req_idx);
            r_dest      = 1'b1;
            r_evid      = req_idx;
            r_free      = fl_count + 1'b1;
          end
        end
      end
      S_DECIDE: begin
        if (found && go) begin
          res_en      = 1'b1;
          mem_wr_en   = 1'b1;
          mem_wr_addr = best_addr;
          mem_wr_live = 1'b1;
          mem_wr_data = best_rec;
          mem_wr_data[rcsa_pkg::REC_FLAGS + rcsa_pkg::FLAG_IDLE] = 1'b0;
          if (req_res) begin
            mem_wr_data[rcsa_pkg::REC_FLAGS + rcsa_pkg::FLAG_RES] = 1'b1;
          end
          r_users = best_rec[rcsa_pkg::REC_USERS +: USE_BITS];
          if (r_users != USE_MAX) begin
            r_users = r_users + 1'b1;
          end
          mem_wr_data[rcsa_pkg::REC_USERS +: USE_BITS] = r_users;
          r_got = best_addr;
          r_hit = 1'b1;
        end
      end
      S_ALLOC: begin
        if (go) begin
          res_en = 1'b1;
          mem_wr_data[rcsa_pkg::REC_VADDR +: 64]     = req_vaddr;
          mem_wr_data[rcsa_pkg::REC_LEN +: 32]       = req_length;
          mem_wr_data[rcsa_pkg::REC_LST +: STAMP_W]  = lcount;
          mem_wr_data[rcsa_pkg::REC_FLAGS + rcsa_pkg::FLAG_VECT] = req_vect;
          mem_wr_data[rcsa_pkg::REC_FLAGS + rcsa_pkg::FLAG_RES]  = req_res;
          mem_wr_data[rcsa_pkg::REC_USERS +: USE_BITS] = USE_BITS'(1);
          mem_wr_live = 1'b1;
          if (fl_count != '0) begin
            // A refused registration leaves the list unchanged, as a pop followed by its push would.
            if (req_refused) begin
              r_status = 1'b1;
            end else begin
              fl_cmd.pop  = 1'b1;
              mem_wr_en   = 1'b1;
              mem_wr_addr = fl_head;
              r_got       = fl_head;
              r_users     = USE_BITS'(1);
              r_free      = fl_count - 1'b1;
            end
          end else if (cache_enable && old_found) begin
            r_ev        = 1'b1;
            r_evid      = old_addr;
            mem_wr_en   = 1'b1;
            mem_wr_addr = old_addr;
            if (req_refused) begin
              mem_wr_live = 1'b0;
              fl_cmd.push = 1'b1;
              fl_cmd.id   = rcsa_pkg::ID_MAX_W'(old_addr);
              r_status    = 1'b1;
              r_free      = fl_count + 1'b1;
            end else begin
              r_got   = old_addr;
              r_users = USE_BITS'(1);
            end
          end else begin
            r_status = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign users_wide = 32'(r_users);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cache_enable  <= 1'b1;
      shared_reuse  <= 1'b0;
      m_axis_tvalid <= 1'b0;
      lcount        <= '0;
      icount        <= '0;
      eval_vld      <= 1'b0;
      found         <= 1'b0;
      old_found     <= 1'b0;
      scan_cnt      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rcsa_pkg::CFG_CACHE_EN: cache_enable <= cfg_data;
          rcsa_pkg::CFG_SHARED:   shared_reuse <= cfg_data;
          default: begin
          end
        endcase
      end
      // Load a new result, else drop the one just taken.
      if (res_en) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            found     <= 1'b0;
            old_found <= 1'b0;
            scan_cnt  <= '0;
            eval_vld  <= 1'b0;
            if (s_axis_tuser == rcsa_pkg::MODE_PUT) begin
              state <= S_PMOD;
            end else if (cache_enable) begin
              state <= S_SCAN;
            end else begin
              state <= S_ALLOC;
            end
          end
        end
        S_PMOD: begin
          if (go) begin
            if (!req_bad && mem_rd_live && put_keep && put_users == '0
                && !rd_flags[rcsa_pkg::FLAG_IDLE]) begin
              icount <= icount + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          eval_vld <= mem_rd_en;
          if (mem_rd_en) begin
            eval_addr <= mem_rd_addr;
            scan_cnt  <= scan_cnt + 1'b1;
          end
          if (eval_vld) begin
            if (cand && (!found || rd_lst < best_stamp)) begin
              found      <= 1'b1;
              best_addr  <= eval_addr;
              best_stamp <= rd_lst;
              best_rec   <= mem_rd_data;
            end
            if (idle_cand && (!old_found || rd_ist < old_stamp)) begin
              old_found <= 1'b1;
              old_addr  <= eval_addr;
              old_stamp <= rd_ist;
            end
          end
          if (scan_cnt == LW'(SLOTS) && !eval_vld) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!found) begin
            state <= S_ALLOC;
          end else if (go) begin
            state <= S_IDLE;
          end
        end
        S_ALLOC: begin
          if (go) begin
            if (mem_wr_en && mem_wr_live && !req_vect) begin
              lcount <= lcount + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_vaddr   <= s_axis_tdata[63:0];
      req_length  <= s_axis_tdata[95:64];
      req_vect    <= s_axis_tdata[96];
      req_res     <= s_axis_tdata[97];
      req_idx     <= IDW'(s_axis_tdata[103:98]);
      req_bad     <= (32'(s_axis_tdata[103:98]) >= SLOTS);
      req_refused <= s_axis_tdata[104];
    end
    if (res_en) begin
      m_axis_tdata <= {1'b0, 7'(r_free), r_dest, 6'(r_evid), r_ev, users_wide[15:0],
                       r_hit, 6'(r_got), r_status};
    end
  end

  rcsa_slot_mem #(
    .SLOTS (SLOTS),
    .REC_W (REC_W)
  ) u_slot_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .rd_live (mem_rd_live),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .wr_live (mem_wr_live)
  );

  rcsa_free_list #(
    .SLOTS (SLOTS)
  ) u_free_list (
    .clk     (clk),
    .rst     (rst),
    .cmd     (fl_cmd),
    .head_id (fl_head),
    .count   (fl_count)
  );

  // The free count never passes the pool size.
  `RCSA_ASSERT_NOW(a_count_range, clk, rst, fl_count <= LW'(SLOTS), "free count overflow")
  // A reuse never reports a failure.
  `RCSA_ASSERT_NOW(a_hit_ok, clk, rst, !(m_axis_tvalid && m_axis_tdata[7] && m_axis_tdata[0]), "hit with failure status")
  // An eviction and a destroy never come from the same transaction.
  `RCSA_ASSERT_NOW(a_ev_dest, clk, rst, !(m_axis_tvalid && m_axis_tdata[24] && m_axis_tdata[31]), "evict and destroy together")
  // A pop lowers the free count by one.
  `RCSA_ASSERT_NEXT(a_pop_count, clk, rst, fl_cmd.pop, fl_count == $past(fl_count) - 1'b1, "pop count mismatch")

endmodule
